// File: hdl/dpds_pkg.sv
// Shared types, constants and the m seed table of the DSI PLL divider search.
`timescale 1ns / 1ps
package dpds_pkg;

  typedef struct packed {
    logic [19:0] pixel_clock_khz;
    logic [4:0]  bits_per_pixel;
    logic [2:0]  lane_count;
    logic        port_a_used;
    logic        port_c_used;
    logic        dual_link;
  } in_req_t;

  typedef struct packed {
    logic        status;
    logic [8:0]  m_seed;
    logic [2:0]  p_divider;
    logic [1:0]  n_log2;
    logic        gate_dsi0;
    logic        gate_dsi1;
    logic [21:0] port_clock_khz;
    logic [22:0] crtc_clock_khz;
  } out_res_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_TGT_SAVE,
    CMD_CAND_START,
    CMD_CAND_EVAL,
    CMD_PORT_START,
    CMD_FINISH,
    CMD_REJECT
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TGT_DIV,
    ST_TGT_CHK,
    ST_CAND_START,
    ST_CAND_DIV,
    ST_CAND_EVAL,
    ST_PORT_START,
    ST_PORT_DIV
  } state_t;

  typedef struct packed {
    logic div_done;
    logic tgt_bad;
    logic search_done;
  } dp_status_t;

  // Divider geometry: 25 bit dividend, 5 bit divisor, four quotient bits a cycle.
  localparam int DIV_W      = 25;
  localparam int DVS_W      = 5;
  localparam int RADIX_BITS = 4;
  localparam int DIV_STEPS  = (DIV_W + RADIX_BITS - 1) / RADIX_BITS;
  localparam int DIV_PAD_W  = DIV_STEPS * RADIX_BITS;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam int CLK_W  = 21;
  localparam int M_W    = 7;
  localparam int P_W    = 3;

  localparam logic [DIV_W-1:0] LINK_MIN_KHZ = 25'd300000;
  localparam logic [DIV_W-1:0] LINK_MAX_KHZ = 25'd1150000;
  // m*ref/(p*n) reduces to m*25000/p on both platforms.
  localparam logic [DIV_W-1:0] REF_STEP_KHZ = 25'd25000;
  localparam logic [DIV_W-1:0] PORT_CLK_MAX = 25'd4194303;
  localparam logic [P_W-1:0]   P_MIN        = 3'd2;
  localparam logic [P_W-1:0]   P_MAX        = 3'd6;
  localparam logic [M_W-1:0]   M_MIN_P0     = 7'd62;
  localparam logic [M_W-1:0]   M_MAX_P0     = 7'd92;
  localparam logic [M_W-1:0]   M_MIN_P1     = 7'd70;
  localparam logic [M_W-1:0]   M_MAX_P1     = 7'd96;
  localparam logic [M_W-1:0]   SEED_BASE_M  = 7'd62;
  localparam logic [1:0]       NLOG_P0      = 2'd0;
  localparam logic [1:0]       NLOG_P1      = 2'd2;

  function automatic logic [8:0] seed_lookup(input logic [5:0] idx);
    logic [8:0] s;
    unique case (idx)
      6'd0:  s = 9'd426;  6'd1:  s = 9'd469;  6'd2:  s = 9'd234;  6'd3:  s = 9'd373;
      6'd4:  s = 9'd442;  6'd5:  s = 9'd221;  6'd6:  s = 9'd110;  6'd7:  s = 9'd311;
      6'd8:  s = 9'd411;  6'd9:  s = 9'd461;  6'd10: s = 9'd486;  6'd11: s = 9'd243;
      6'd12: s = 9'd377;  6'd13: s = 9'd188;  6'd14: s = 9'd350;  6'd15: s = 9'd175;
      6'd16: s = 9'd343;  6'd17: s = 9'd427;  6'd18: s = 9'd213;  6'd19: s = 9'd106;
      6'd20: s = 9'd53;   6'd21: s = 9'd282;  6'd22: s = 9'd397;  6'd23: s = 9'd454;
      6'd24: s = 9'd227;  6'd25: s = 9'd113;  6'd26: s = 9'd56;   6'd27: s = 9'd284;
      6'd28: s = 9'd142;  6'd29: s = 9'd71;   6'd30: s = 9'd35;   6'd31: s = 9'd273;
      6'd32: s = 9'd136;  6'd33: s = 9'd324;  6'd34: s = 9'd418;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/dpds_div.sv
// Iterative restoring divider, four quotient bits per cycle.
`timescale 1ns / 1ps
module dpds_div import dpds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_PAD_W-1:0] sh_r, sh_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt, dvs_r;
  logic [DVS_W:0]       trial;
  logic [CNT_W-1:0]     cnt_r;
  logic                 run_r, done_r;

  // Each step shifts one dividend bit into the remainder and one quotient bit in at the bottom.
  always_comb begin
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    trial   = '0;
    for (int k = 0; k < RADIX_BITS; k++) begin
      trial  = {rem_nxt, sh_nxt[DIV_PAD_W-1]};
      sh_nxt = {sh_nxt[DIV_PAD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt   = DVS_W'(trial - {1'b0, dvs_r});
        sh_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[DVS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= DIV_PAD_W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = sh_r[DIV_W-1:0];

endmodule

// File: hdl/dpds_datapath.sv
// Datapath: request registers, divider operand selection, best-pair search and result.
`timescale 1ns / 1ps
module dpds_datapath import dpds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic       mode,
  input  in_req_t    in_req,
  output dp_status_t status,
  output logic       out_valid,
  output out_res_t   out_res
);

  in_req_t          req_r;
  logic [CLK_W-1:0] target_r, best_r, best_q_r, cand_q, diff;
  logic [M_W-1:0]   m_r, best_m_r, m_min, m_max;
  logic [P_W-1:0]   p_r, best_p_r;
  logic             first_r, tgt_bad_r, upd, out_valid_r;
  logic [CLK_W-1:0] best_new;
  out_res_t         out_r;
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_a, div_q, port_sat;
  logic [DVS_W-1:0] div_b;
  logic [5:0]       seed_idx;

  assign m_min = mode ? M_MIN_P1 : M_MIN_P0;
  assign m_max = mode ? M_MAX_P1 : M_MAX_P0;

  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    unique case (cmd)
      CMD_LOAD: begin
        div_start = 1'b1;
        div_a = DIV_W'(in_req.pixel_clock_khz) * DIV_W'(in_req.bits_per_pixel)
              + DIV_W'(in_req.lane_count >> 1);
        div_b = DVS_W'(in_req.lane_count);
      end
      CMD_CAND_START: begin
        div_start = 1'b1;
        div_a = DIV_W'(m_r) * REF_STEP_KHZ;
        div_b = DVS_W'(p_r);
      end
      CMD_PORT_START: begin
        div_start = 1'b1;
        div_a = DIV_W'(best_q_r) * DIV_W'(req_r.lane_count)
              + DIV_W'(req_r.bits_per_pixel >> 1);
        div_b = req_r.bits_per_pixel;
      end
      default: begin
      end
    endcase
  end

  dpds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Candidate compare: strict less-than keeps the first pair among equal errors.
  assign cand_q   = div_q[CLK_W-1:0];
  assign diff     = (target_r > cand_q) ? target_r - cand_q : cand_q - target_r;
  assign upd      = first_r || (diff < best_r);
  assign best_new = upd ? diff : best_r;

  assign status.div_done    = div_done;
  assign status.tgt_bad     = tgt_bad_r;
  assign status.search_done = (best_new == '0) || ((m_r == m_max) && (p_r == P_MAX));

  assign port_sat = (div_q > PORT_CLK_MAX) ? PORT_CLK_MAX : div_q;
  assign seed_idx = 6'(best_m_r - SEED_BASE_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd == CMD_FINISH) || (cmd == CMD_REJECT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        req_r <= in_req;
      end
      CMD_TGT_SAVE: begin
        tgt_bad_r <= (req_r.lane_count == '0) || (div_q < LINK_MIN_KHZ)
                  || (div_q > LINK_MAX_KHZ);
        target_r  <= div_q[CLK_W-1:0];
        m_r       <= m_min;
        p_r       <= P_MIN;
        first_r   <= 1'b1;
      end
      CMD_CAND_EVAL: begin
        first_r <= 1'b0;
        if (upd) begin
          best_r   <= diff;
          best_m_r <= m_r;
          best_p_r <= p_r;
          best_q_r <= cand_q;
        end
        if (p_r == P_MAX) begin
          p_r <= P_MIN;
          m_r <= m_r + 1'b1;
        end else begin
          p_r <= p_r + 1'b1;
        end
      end
      CMD_FINISH: begin
        out_r.status         <= 1'b0;
        out_r.m_seed         <= seed_lookup(seed_idx);
        out_r.p_divider      <= best_p_r;
        out_r.n_log2         <= mode ? NLOG_P1 : NLOG_P0;
        out_r.gate_dsi0      <= req_r.port_a_used;
        out_r.gate_dsi1      <= req_r.port_c_used;
        out_r.port_clock_khz <= port_sat[21:0];
        out_r.crtc_clock_khz <= req_r.dual_link ? {port_sat[21:0], 1'b0}
                                                : {1'b0, port_sat[21:0]};
      end
      CMD_REJECT: begin
        out_r <= '{status: 1'b1, default: '0};
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// File: hdl/dpds_ctrl.sv
// Controller state machine sequencing target, candidate and port divisions.
`timescale 1ns / 1ps
module dpds_ctrl import dpds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = ST_TGT_DIV;
        end
      end
      ST_TGT_DIV: begin
        if (status.div_done) begin
          cmd       = CMD_TGT_SAVE;
          state_nxt = ST_TGT_CHK;
        end
      end
      ST_TGT_CHK: begin
        if (status.tgt_bad) begin
          cmd       = CMD_REJECT;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_CAND_START;
        end
      end
      ST_CAND_START: begin
        cmd       = CMD_CAND_START;
        state_nxt = ST_CAND_DIV;
      end
      ST_CAND_DIV: begin
        if (status.div_done) begin
          state_nxt = ST_CAND_EVAL;
        end
      end
      ST_CAND_EVAL: begin
        cmd       = CMD_CAND_EVAL;
        state_nxt = status.search_done ? ST_PORT_START : ST_CAND_START;
      end
      ST_PORT_START: begin
        cmd       = CMD_PORT_START;
        state_nxt = ST_PORT_DIV;
      end
      ST_PORT_DIV: begin
        if (status.div_done) begin
          cmd       = CMD_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: hdl/dsi_pll_divider_search_top.sv
// Top level of the DSI PLL divider search: config register, controller and datapath.
`timescale 1ns / 1ps
// Sequence: a rejected request raises the result strobe after the target division and check; an accepted
// one runs a division per (m, p) candidate tried, up to 155 candidates, then the port division.
// Throughput: one request at a time; busy stays high until the result strobe is issued.
// The shared four-bits-per-cycle divider (7 steps) sets the cost of every candidate.
// Reset (rst_n low, synchronous) returns to idle and sets platform_mode to 0.
// The result is shown for one cycle on out_valid; the receiver cannot stall it.
module dsi_pll_divider_search_top import dpds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  logic       mode_r;
  cmd_t       cmd;
  dp_status_t status;

  // platform_mode: 0 selects the 25 MHz reference, 1 the 100 MHz reference with n = 4.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // The controller only issues commands; all arithmetic lives in the datapath.
  dpds_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  dpds_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .mode      (mode_r),
    .in_req    (in_req),
    .status    (status),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // An accepted request always makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted but block not busy");

  // The result strobe comes only once the controller has gone back to idle.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while still busy");

  // A rejected request carries zero in every other field; the check covers p_divider and port_clock_khz.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status) |-> (out_res.p_divider == '0 && out_res.port_clock_khz == '0))
    else $error("rejected result has nonzero fields");

  // An accepted request always reports a post divider from the search range.
  a_p_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.status) |-> (out_res.p_divider >= P_MIN && out_res.p_divider <= P_MAX))
    else $error("post divider out of range");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the DSI PLL divider search block.
`timescale 1ns / 1ps
module testbench;
  import dpds_pkg::*;

  // Scoreboard: predicts one result per accepted request and checks results in order.
  class divider_scoreboard;
    out_res_t pending_results[$];
    bit       plat_mode;
    int       fail_count;

    function automatic out_res_t compute_divider(in_req_t rq);
      out_res_t r;
      int unsigned seeds[35] = '{426, 469, 234, 373, 442, 221, 110, 311, 411,
        461, 486, 243, 377, 188, 350, 175, 343, 427, 213,
        106, 53, 282, 397, 454, 227, 113, 56, 284, 142,
        71, 35, 273, 136, 324, 418};
      int unsigned pclk, bpp, lanes, tgt, refk, nd, mlo, mhi, best, bm, bp, d, dsi, port;
      r = '0;
      pclk = 32'(rq.pixel_clock_khz);
      bpp = 32'(rq.bits_per_pixel);
      lanes = 32'(rq.lane_count);
      tgt = 0;
      if (lanes != 0) tgt = (pclk * bpp + lanes / 2) / lanes;
      if (lanes == 0 || tgt < 300000 || tgt > 1150000) begin
        r.status = 1'b1;
        return r;
      end
      if (plat_mode) begin
        refk = 100000; nd = 4; mlo = 70; mhi = 96;
      end else begin
        refk = 25000; nd = 1; mlo = 62; mhi = 92;
      end
      bm = mlo;
      bp = 2;
      dsi = (mlo * refk) / (2 * nd);
      best = (tgt > dsi) ? tgt - dsi : dsi - tgt;
      for (int unsigned m = mlo; m <= mhi && best != 0; m++) begin
        for (int unsigned p = 2; p <= 6 && best != 0; p++) begin
          dsi = (m * refk) / (p * nd);
          d = (tgt > dsi) ? tgt - dsi : dsi - tgt;
          if (d < best) begin
            best = d; bm = m; bp = p;
          end
        end
      end
      dsi = (bm * refk) / (bp * nd);
      port = 0;
      if (bpp != 0) port = (dsi * lanes + bpp / 2) / bpp;
      if (port > 4194303) port = 4194303;
      r.m_seed = 9'(seeds[(bm - 62) % 35]);
      r.p_divider = 3'(bp);
      r.n_log2 = plat_mode ? 2'd2 : 2'd0;
      r.gate_dsi0 = rq.port_a_used;
      r.gate_dsi1 = rq.port_c_used;
      r.port_clock_khz = 22'(port);
      r.crtc_clock_khz = 23'(rq.dual_link ? port * 2 : port);
      return r;
    endfunction

    function void note_request(in_req_t rq);
      pending_results.push_back(compute_divider(rq));
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      if (got.m_seed !== want.m_seed)
        $display("%0t: m_seed expected %0d actual %0d", $time, want.m_seed, got.m_seed);
      if (got.p_divider !== want.p_divider)
        $display("%0t: p_divider expected %0d actual %0d", $time, want.p_divider,
                 got.p_divider);
      if (got.n_log2 !== want.n_log2)
        $display("%0t: n_log2 expected %0d actual %0d", $time, want.n_log2, got.n_log2);
      if (got.gate_dsi0 !== want.gate_dsi0)
        $display("%0t: gate_dsi0 expected %0d actual %0d", $time, want.gate_dsi0,
                 got.gate_dsi0);
      if (got.gate_dsi1 !== want.gate_dsi1)
        $display("%0t: gate_dsi1 expected %0d actual %0d", $time, want.gate_dsi1,
                 got.gate_dsi1);
      if (got.port_clock_khz !== want.port_clock_khz)
        $display("%0t: port_clock_khz expected %0d actual %0d", $time,
                 want.port_clock_khz, got.port_clock_khz);
      if (got.crtc_clock_khz !== want.crtc_clock_khz)
        $display("%0t: crtc_clock_khz expected %0d actual %0d", $time,
                 want.crtc_clock_khz, got.crtc_clock_khz);
      if (got !== want) fail_count++;
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_res_t out_res;
  logic     cfg_we;
  logic     cfg_wdata;

  divider_scoreboard sb;
  int                idle_pct;

  dsi_pll_divider_search_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Results cannot be stalled, so every strobed cycle is checked as it ends.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_res);
  end

  // Hard stop: ends the run as failed if the 417 requests have not all finished by then.
  initial begin
    #20000000;
    $display("testbench NOT OK");
    $finish;
  end

  // Presents one request, idling at random first, and holds start until the block is no longer busy.
  task automatic send_request(in_req_t rq);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    in_req <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(rq);
    start <= 1'b0;
    in_req <= in_req_t'($bits(in_req_t)'($urandom));
    @(posedge clk);
  endtask

  // Waits until every predicted result has arrived, plus a short settle period.
  task automatic drain_results();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_mode(bit mode);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.plat_mode = mode;
  endtask

  // Picks a mostly in-range request; a slice of the traffic is unconstrained noise.
  function automatic in_req_t random_request();
    in_req_t rq;
    int unsigned bpp_opts[3] = '{16, 18, 24};
    int unsigned bpp, lanes, tgt;
    rq = in_req_t'($bits(in_req_t)'($urandom));
    if ($urandom_range(9) < 8) begin
      bpp = bpp_opts[$urandom_range(2)];
      lanes = $urandom_range(4, 1);
      tgt = $urandom_range(1150000, 300000);
      rq.bits_per_pixel = 5'(bpp);
      rq.lane_count = 3'(lanes);
      rq.pixel_clock_khz = 20'(tgt * lanes / bpp);
    end
    return rq;
  endfunction

  task automatic send_fields(int unsigned pclk, int unsigned bpp, int unsigned lanes,
                             bit pa, bit pc, bit dual);
    in_req_t rq;
    rq.pixel_clock_khz = 20'(pclk);
    rq.bits_per_pixel = 5'(bpp);
    rq.lane_count = 3'(lanes);
    rq.port_a_used = pa;
    rq.port_c_used = pc;
    rq.dual_link = dual;
    send_request(rq);
  endtask

  initial begin
    sb = new();
    idle_pct = 27;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset platform: range edges, zero lanes and bpp, odd values.
    send_fields(75000, 16, 4, 1, 0, 0);     // target exactly at the low bound
    send_fields(74999, 16, 4, 0, 1, 1);     // just below the low bound
    send_fields(287500, 16, 4, 1, 1, 1);    // target exactly at the high bound
    send_fields(287501, 16, 4, 1, 1, 0);    // just above the high bound
    send_fields(1048575, 31, 7, 1, 1, 1);   // all-ones fields
    send_fields(0, 0, 0, 0, 0, 0);          // all zeros
    send_fields(50000, 24, 0, 1, 0, 1);     // zero lane count
    send_fields(50000, 0, 2, 1, 0, 1);      // zero bits per pixel
    send_fields(100000, 24, 4, 1, 1, 1);
    send_fields(18750, 16, 1, 0, 1, 1);     // target at the low bound, exact hit
    send_fields(300000, 3, 1, 1, 0, 0);     // bpp off the nominal set
    send_fields(140000, 31, 6, 0, 1, 1);    // lanes off the nominal set
    write_mode(1'b1);
    send_fields(75000, 16, 4, 1, 0, 1);
    send_fields(287500, 16, 4, 0, 1, 1);
    send_fields(1048575, 31, 7, 1, 1, 1);
    send_fields(148500, 24, 4, 1, 1, 0);
    send_fields(300000, 1, 1, 0, 0, 1);

    // Random part in three idling phases, switching platforms between batches.
    for (int i = 0; i < 400; i++) begin
      if (i == 130) idle_pct = 77;
      if (i == 260) idle_pct = 0;
      if (i % 50 == 0) write_mode(i % 100 == 0 ? 1'b0 : 1'b1);
      if (i == 200) drain_results();
      send_request(random_request());
    end

    drain_results();
    if (sb.fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
